// File: rtl/core/ffh_pkg.sv
// Shared types, constants and codes for the first-fit heap allocator.
// No dependencies; the allocator, the size rounder and the testbench import this package.
package ffh_pkg;

    localparam int unsigned ARENA_BYTES       = 65536;
    localparam int unsigned HEADER_BYTES      = 16;
    localparam int unsigned MIN_PAYLOAD_BYTES = 16;
    localparam int unsigned SLOT_COUNT        = ARENA_BYTES / 8;
    localparam int unsigned SLOT_W            = $clog2(SLOT_COUNT);
    localparam int unsigned OFF_W             = $clog2(ARENA_BYTES);
    localparam int unsigned ARENA_W           = OFF_W + 1;

    localparam logic [2:0] ST_GRANTED  = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_NO_SPACE = 3'd2;
    localparam logic [2:0] ST_FREED    = 3'd3;
    localparam logic [2:0] ST_IGNORED  = 3'd4;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [16:0] request_size;
        logic [12:0] request_alignment;
        logic [15:0] release_offset;
    } ffh_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] payload_offset;
    } ffh_res_t;

    // one block header, kept per 8-byte slot of block start
    typedef struct packed {
        logic [OFF_W-1:0]  size;
        logic              free;
        logic [SLOT_W-1:0] prev;
    } ffh_hdr_t;

    localparam int unsigned HDR_W = $bits(ffh_hdr_t);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_RD,
        S_A_SPLIT,
        S_FIX,
        S_F_RD,
        S_F_NXT,
        S_F_WS,
        S_F_PRV
    } ffh_state_t;

endpackage

// File: rtl/core/first_fit_heap_allocator.sv
// First-fit heap allocator: header walk, split and coalesce over a header memory and a
// block-start valid memory. A zero-size allocate and a free rejected at the port are
// answered straight from idle; other requests read headers first. One header read per
// cycle sets the allocate rate. Result strobes are one cycle wide; the receiver cannot
// stall. Reset and each config write run a clearing pass over all 8192 slots (busy) and
// set up one free block. Uses ffh_pkg and RAMs.
module first_fit_heap_allocator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ffh_pkg::ffh_req_t req,
    output logic              done,
    output ffh_pkg::ffh_res_t result,
    input  logic              cfg_we,
    input  logic [16:0]       cfg_wdata
);
    import ffh_pkg::*;

    ffh_state_t        state_reg, state_next;
    logic [SLOT_W-1:0] cur_slot_reg, cur_slot_next;
    logic [OFF_W-1:0]  cur_size_reg, cur_size_next;
    logic [SLOT_W-1:0] cur_prev_reg, cur_prev_next;
    logic [17:0]       want_reg, want_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic [SLOT_W-1:0] fix_prev_reg, fix_prev_next;
    logic              fix_ret_reg, fix_ret_next;
    ffh_res_t          res_reg, res_next;
    logic              done_reg, done_next;
    logic [ARENA_W-1:0] arena_reg, arena_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;

    logic              ram_we, ram_re;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    ffh_hdr_t          ram_wdata, rd_hdr;
    logic [HDR_W-1:0]  ram_rdata;

    logic              vld_we, vld_re;
    logic [SLOT_W-1:0] vld_waddr, vld_raddr;
    logic              vld_wdata, vld_rdata;

    logic [17:0]        want;
    logic               zero_size;
    logic [OFF_W-1:0]   cur_start;
    logic [ARENA_W-1:0] rd_end, cur_end, rest, rel_start, split_end, cfg_arena;
    logic [18:0]        split_need;

    ffh_size_round u_round (
        .request_size      (req.request_size),
        .request_alignment (req.request_alignment),
        .want              (want),
        .zero              (zero_size)
    );

    ffh_hdr_ram #(
        .ADDR_W (SLOT_W),
        .DATA_W (HDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // one bit per slot: a block header starts there
    ffh_hdr_ram #(
        .ADDR_W (SLOT_W),
        .DATA_W (1)
    ) u_vld_ram (
        .clk   (clk),
        .we    (vld_we),
        .waddr (vld_waddr),
        .wdata (vld_wdata),
        .re    (vld_re),
        .raddr (vld_raddr),
        .rdata (vld_rdata)
    );

    assign rd_hdr     = ram_rdata;
    assign cur_start  = {cur_slot_reg, 3'b000};
    assign rd_end     = {1'b0, rd_slot_reg, 3'b000} + ARENA_W'(HEADER_BYTES)
                        + {1'b0, rd_hdr.size};
    assign cur_end    = {1'b0, cur_start} + ARENA_W'(HEADER_BYTES) + {1'b0, cur_size_reg};
    assign rest       = {1'b0, cur_start} + ARENA_W'(HEADER_BYTES) + want_reg[ARENA_W-1:0];
    assign split_end  = rest + ARENA_W'(HEADER_BYTES) + {1'b0, cur_size_reg};
    assign split_need = {1'b0, want_reg} + 19'(HEADER_BYTES + MIN_PAYLOAD_BYTES);
    assign rel_start  = {1'b0, req.release_offset} - ARENA_W'(HEADER_BYTES);
    assign cfg_arena  = (cfg_wdata <= 17'(HEADER_BYTES + MIN_PAYLOAD_BYTES)
                         || cfg_wdata > 17'(ARENA_BYTES)) ? ARENA_W'(ARENA_BYTES) : cfg_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            done_reg  <= 1'b0;
            arena_reg <= ARENA_W'(ARENA_BYTES);
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            arena_reg <= arena_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_slot_reg <= cur_slot_next;
        cur_size_reg <= cur_size_next;
        cur_prev_reg <= cur_prev_next;
        want_reg     <= want_next;
        rd_slot_reg  <= rd_slot_next;
        fix_prev_reg <= fix_prev_next;
        fix_ret_reg  <= fix_ret_next;
        res_reg      <= res_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cur_slot_next = cur_slot_reg;
        cur_size_next = cur_size_reg;
        cur_prev_next = cur_prev_reg;
        want_next     = want_reg;
        rd_slot_next  = rd_slot_reg;
        fix_prev_next = fix_prev_reg;
        fix_ret_next  = fix_ret_reg;
        res_next      = res_reg;
        done_next     = 1'b0;
        arena_next    = arena_reg;
        clr_next      = clr_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = '0;
        vld_we        = 1'b0;
        vld_waddr     = '0;
        vld_wdata     = 1'b0;
        vld_re        = 1'b0;
        vld_raddr     = '0;

        unique case (state_reg)
            S_INIT:
            begin
                // clearing pass over the valid memory; slot 0 becomes the one free block
                ram_we     = (clr_reg == '0);
                ram_wdata  = '{size: OFF_W'(arena_reg - ARENA_W'(HEADER_BYTES)),
                               free: 1'b1, prev: '0};
                vld_we     = 1'b1;
                vld_waddr  = clr_reg;
                vld_wdata  = (clr_reg == '0);
                clr_next   = clr_reg + SLOT_W'(1);
                if (cfg_we)
                begin
                    arena_next = cfg_arena;
                    clr_next   = '0;
                end
                else if (clr_reg == SLOT_W'(SLOT_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    arena_next = cfg_arena;
                    clr_next   = '0;
                    state_next = S_INIT;
                end
                else if (start)
                begin
                    if (req.req_type == REQ_ALLOC)
                    begin
                        if (zero_size)
                        begin
                            res_next  = '{status: ST_ZERO, payload_offset: '0};
                            done_next = 1'b1;
                        end
                        else
                        begin
                            want_next    = want;
                            cur_slot_next = '0;
                            rd_slot_next = '0;
                            ram_re       = 1'b1;
                            state_next   = S_A_RD;
                        end
                    end
                    else if (req.release_offset < 16'(HEADER_BYTES)
                             || rel_start[2:0] != 3'b000 || rel_start >= arena_reg)
                    begin
                        res_next  = '{status: ST_IGNORED, payload_offset: '0};
                        done_next = 1'b1;
                    end
                    else
                    begin
                        cur_slot_next = rel_start[OFF_W-1:3];
                        rd_slot_next  = rel_start[OFF_W-1:3];
                        ram_re        = 1'b1;
                        ram_raddr     = rel_start[OFF_W-1:3];
                        vld_re        = 1'b1;
                        vld_raddr     = rel_start[OFF_W-1:3];
                        state_next    = S_F_RD;
                    end
                end
            end
            S_A_RD:
            begin
                if (rd_hdr.free && {2'b00, rd_hdr.size} >= want_reg)
                begin
                    cur_slot_next = rd_slot_reg;
                    res_next      = '{status: ST_GRANTED,
                                      payload_offset: {rd_slot_reg, 3'b000} + 16'(HEADER_BYTES)};
                    ram_we        = 1'b1;
                    ram_waddr     = rd_slot_reg;
                    if ({3'b000, rd_hdr.size} >= split_need)
                    begin
                        ram_wdata     = '{size: want_reg[OFF_W-1:0], free: 1'b0,
                                          prev: rd_hdr.prev};
                        // remainder size, kept for the split beat
                        cur_size_next = rd_hdr.size - want_reg[OFF_W-1:0]
                                        - OFF_W'(HEADER_BYTES);
                        state_next    = S_A_SPLIT;
                    end
                    else
                    begin
                        ram_wdata  = '{size: rd_hdr.size, free: 1'b0, prev: rd_hdr.prev};
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (rd_end >= arena_reg)
                begin
                    res_next   = '{status: ST_NO_SPACE, payload_offset: '0};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_slot_next = rd_end[OFF_W-1:3];
                    ram_re       = 1'b1;
                    ram_raddr    = rd_end[OFF_W-1:3];
                end
            end
            S_A_SPLIT:
            begin
                // cur_size_reg holds the remainder payload here
                ram_we    = 1'b1;
                ram_waddr = rest[OFF_W-1:3];
                ram_wdata = '{size: cur_size_reg, free: 1'b1, prev: cur_slot_reg};
                vld_we    = 1'b1;
                vld_waddr = rest[OFF_W-1:3];
                vld_wdata = 1'b1;
                if (split_end < arena_reg)
                begin
                    rd_slot_next  = split_end[OFF_W-1:3];
                    ram_re        = 1'b1;
                    ram_raddr     = split_end[OFF_W-1:3];
                    fix_prev_next = rest[OFF_W-1:3];
                    fix_ret_next  = 1'b0;
                    state_next    = S_FIX;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FIX:
            begin
                ram_we    = 1'b1;
                ram_waddr = rd_slot_reg;
                ram_wdata = '{size: rd_hdr.size, free: rd_hdr.free, prev: fix_prev_reg};
                if (fix_ret_reg)
                begin
                    state_next = S_F_WS;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_F_RD:
            begin
                cur_size_next = rd_hdr.size;
                cur_prev_next = rd_hdr.prev;
                if (!vld_rdata)
                begin
                    // offset is not the payload of any block
                    res_next   = '{status: ST_IGNORED, payload_offset: '0};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (rd_end < arena_reg)
                begin
                    rd_slot_next = rd_end[OFF_W-1:3];
                    ram_re       = 1'b1;
                    ram_raddr    = rd_end[OFF_W-1:3];
                    state_next   = S_F_NXT;
                end
                else
                begin
                    state_next = S_F_WS;
                end
            end
            S_F_NXT:
            begin
                state_next = S_F_WS;
                if (rd_hdr.free)
                begin
                    cur_size_next = cur_size_reg + OFF_W'(HEADER_BYTES) + rd_hdr.size;
                    vld_we        = 1'b1;
                    vld_waddr     = rd_slot_reg;
                    vld_wdata     = 1'b0;
                    if (rd_end < arena_reg)
                    begin
                        rd_slot_next  = rd_end[OFF_W-1:3];
                        ram_re        = 1'b1;
                        ram_raddr     = rd_end[OFF_W-1:3];
                        fix_prev_next = cur_slot_reg;
                        fix_ret_next  = 1'b1;
                        state_next    = S_FIX;
                    end
                end
            end
            S_F_WS:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_slot_reg;
                ram_wdata = '{size: cur_size_reg, free: 1'b1, prev: cur_prev_reg};
                res_next  = '{status: ST_FREED, payload_offset: '0};
                if (cur_slot_reg != '0)
                begin
                    rd_slot_next = cur_prev_reg;
                    ram_re       = 1'b1;
                    ram_raddr    = cur_prev_reg;
                    state_next   = S_F_PRV;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_F_PRV:
            begin
                if (rd_hdr.free)
                begin
                    // predecessor absorbs the freed block
                    ram_we    = 1'b1;
                    ram_waddr = rd_slot_reg;
                    ram_wdata = '{size: rd_hdr.size + OFF_W'(HEADER_BYTES) + cur_size_reg,
                                  free: 1'b1, prev: rd_hdr.prev};
                    vld_we    = 1'b1;
                    vld_waddr = cur_slot_reg;
                    vld_wdata = 1'b0;
                    if (cur_end < arena_reg)
                    begin
                        fix_prev_next = rd_slot_reg;
                        fix_ret_next  = 1'b0;
                        rd_slot_next  = cur_end[OFF_W-1:3];
                        ram_re        = 1'b1;
                        ram_raddr     = cur_end[OFF_W-1:3];
                        state_next    = S_FIX;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_grant_nonnull: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_GRANTED |-> result.payload_offset != 16'd0)
        else $error("granted beat with null offset");

    a_other_null: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != ST_GRANTED |-> result.payload_offset == 16'd0)
        else $error("non-granted beat carries an offset");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !cfg_we |=> busy || done)
        else $error("accepted request neither busy nor answered");

    a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && ram_re |-> ram_waddr != ram_raddr)
        else $error("header read and write to same slot in one cycle");

endmodule

// File: rtl/core/ffh_hdr_ram.sv
// Simple dual-port header memory, one write and one registered read per cycle.
// Generic; no package dependency.
module ffh_hdr_ram #(
    parameter int unsigned ADDR_W = 13,
    parameter int unsigned DATA_W = 30
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/ffh_size_round.sv
// Rounds a request size up to its alignment (min 8, raised to a power of two).
// Depends on ffh_pkg.
module ffh_size_round (
    input  logic [16:0] request_size,
    input  logic [12:0] request_alignment,
    output logic [17:0] want,
    output logic        zero
);
    import ffh_pkg::*;

    logic [12:0] mask;

    always_comb
    begin
        if (request_alignment < 13'd8)
        begin
            mask = 13'd7;
        end
        else
        begin
            mask = request_alignment - 13'd1;
        end
        // smear to the next power of two minus one
        mask = mask | (mask >> 1);
        mask = mask | (mask >> 2);
        mask = mask | (mask >> 4);
        mask = mask | (mask >> 8);
        want = ({1'b0, request_size} + {5'd0, mask}) & ~{5'd0, mask};
        zero = (request_size == 17'd0);
    end

endmodule

// File: tb/tb_top.sv
// Testbench for first_fit_heap_allocator: random and directed alloc/free beats.
// Checks every result against a behavioral heap model; depends on ffh_pkg and the RTL.
module tb_top;
    import ffh_pkg::*;

    localparam int SLOTS = 8192;
    localparam int LIMIT = 20000000;

    class heap_scoreboard;
        int unsigned arena;
        int unsigned blk_size[SLOTS];
        int unsigned blk_prev[SLOTS];
        bit          blk_free[SLOTS];
        bit          blk_valid[SLOTS];
        ffh_res_t    pending[$];
        int unsigned live[$];
        int          errors;

        function void rebuild(int unsigned bytes);
            arena = bytes;
            for (int i = 0; i < SLOTS; i++)
            begin
                blk_size[i] = 0;
                blk_prev[i] = 0;
                blk_free[i] = 0;
                blk_valid[i] = 0;
            end
            blk_size[0] = arena - HEADER_BYTES;
            blk_free[0] = 1;
            blk_valid[0] = 1;
            live.delete();
        endfunction

        function void set_arena(logic [16:0] v);
            int unsigned x;
            x = v;
            if (x <= HEADER_BYTES + MIN_PAYLOAD_BYTES || x > ARENA_BYTES)
                x = ARENA_BYTES;
            rebuild(x);
        endfunction

        function int unsigned after(int unsigned s);
            return s + HEADER_BYTES + blk_size[s >> 3];
        endfunction

        function void merge_fwd(int unsigned s);
            int unsigned n, a;
            n = after(s);
            if (n >= arena)
                return;
            if (!blk_valid[n >> 3] || !blk_free[n >> 3])
                return;
            a = after(n);
            blk_size[s >> 3] += HEADER_BYTES + blk_size[n >> 3];
            blk_valid[n >> 3] = 0;
            if (a < arena)
                blk_prev[a >> 3] = s;
        endfunction

        function ffh_res_t allocate(int unsigned size, int unsigned align);
            ffh_res_t r;
            int unsigned a, p, want, s, rest, nx;
            r = '0;
            a = align < 8 ? 8 : align;
            if (size == 0)
            begin
                r.status = ST_ZERO;
                return r;
            end
            if ((a & (a - 1)) != 0)
            begin
                p = 8;
                while (p < a && p < 8192)
                    p <<= 1;
                a = p;
            end
            want = (size + a - 1) & ~(a - 1);
            s = 0;
            for (int g = 0; g < SLOTS && s < arena; g++)
            begin
                if (!blk_valid[s >> 3])
                    break;
                if (blk_free[s >> 3] && blk_size[s >> 3] >= want)
                begin
                    if (blk_size[s >> 3] >= want + HEADER_BYTES + MIN_PAYLOAD_BYTES)
                    begin
                        rest = s + HEADER_BYTES + want;
                        blk_size[rest >> 3] = blk_size[s >> 3] - want - HEADER_BYTES;
                        blk_free[rest >> 3] = 1;
                        blk_valid[rest >> 3] = 1;
                        blk_prev[rest >> 3] = s;
                        nx = after(rest);
                        if (nx < arena)
                            blk_prev[nx >> 3] = rest;
                        blk_size[s >> 3] = want;
                    end
                    blk_free[s >> 3] = 0;
                    r.status = ST_GRANTED;
                    r.payload_offset = 16'(s + HEADER_BYTES);
                    live.push_back(s + HEADER_BYTES);
                    return r;
                end
                s = after(s);
            end
            r.status = ST_NO_SPACE;
            return r;
        endfunction

        function ffh_res_t release_blk(int unsigned off);
            ffh_res_t r;
            int unsigned s, p;
            r = '0;
            r.status = ST_IGNORED;
            if (off < HEADER_BYTES)
                return r;
            s = off - HEADER_BYTES;
            if ((s & 7) != 0 || s >= arena || !blk_valid[s >> 3])
                return r;
            blk_free[s >> 3] = 1;
            merge_fwd(s);
            if (s != 0)
            begin
                p = blk_prev[s >> 3];
                if (p < arena && (p & 7) == 0 && blk_valid[p >> 3] && blk_free[p >> 3])
                    merge_fwd(p);
            end
            foreach (live[i])
                if (live[i] == off)
                begin
                    live.delete(i);
                    break;
                end
            r.status = ST_FREED;
            return r;
        endfunction

        function void note_request(ffh_req_t q);
            if (q.req_type == REQ_ALLOC)
                pending.push_back(allocate(q.request_size, q.request_alignment));
            else
                pending.push_back(release_blk(q.release_offset));
        endfunction

        function void check_result(ffh_res_t got);
            ffh_res_t exp_r;
            if (pending.size() == 0)
            begin
                $error("unexpected result status=%0d offset=%0d", got.status,
                       got.payload_offset);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.status !== exp_r.status)
            begin
                $error("status: expected %0d, got %0d", exp_r.status, got.status);
                errors++;
            end
            if (got.payload_offset !== exp_r.payload_offset)
            begin
                $error("payload_offset: expected %0d, got %0d", exp_r.payload_offset,
                       got.payload_offset);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    ffh_req_t    req = '0;
    logic        done;
    ffh_res_t    result;
    logic        cfg_we = 0;
    logic [16:0] cfg_wdata = '0;

    heap_scoreboard sb;
    int unsigned cycles = 0;
    int unsigned sent = 0;

    first_fit_heap_allocator u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("first_fit_heap_allocator test failed");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_result(result);

    // drops start only when the gap is not empty
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (n > 0)
        begin
            start <= 0;
            repeat (n) @(posedge clk);
        end
    endtask

    // one request beat; holds start until accepted
    task automatic send(ffh_req_t q, bit gap);
        start <= 1;
        req <= q;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(q);
        sent++;
        if (gap && $urandom_range(0, 2) == 0)
            idle_gap();
    endtask

    task automatic drain();
        start <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_arena(logic [16:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        sb.set_arena(v);
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic ffh_req_t mk_alloc(int unsigned size, int unsigned align);
        ffh_req_t q;
        q = '0;
        q.req_type = REQ_ALLOC;
        q.request_size = 17'(size);
        q.request_alignment = 13'(align);
        q.release_offset = 16'($urandom);
        return q;
    endfunction

    function automatic ffh_req_t mk_free(int unsigned off);
        ffh_req_t q;
        q = '0;
        q.req_type = REQ_FREE;
        q.request_size = 17'($urandom);
        q.request_alignment = 13'($urandom);
        q.release_offset = 16'(off);
        return q;
    endfunction

    function automatic ffh_req_t rand_req();
        int unsigned k, sz, al;
        k = $urandom_range(0, 99);
        if (k < 50)
        begin
            sz = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 131071)
                                              : $urandom_range(0, 600);
            al = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                             : (1 << $urandom_range(0, 7));
            return mk_alloc(sz, al);
        end
        if (k < 90 && sb.live.size() != 0)
            return mk_free(sb.live[$urandom_range(0, sb.live.size() - 1)]);
        return mk_free($urandom_range(0, 65535));
    endfunction

    initial
    begin
        int unsigned a;
        sb = new();
        sb.rebuild(ARENA_BYTES);
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        // directed: zero size, alignment corners, exhaustion, null/bad/double free
        send(mk_alloc(0, 8), 0);
        send(mk_alloc(1, 0), 0);
        send(mk_alloc(17, 3), 0);
        send(mk_alloc(100, 4096), 0);
        send(mk_alloc(5, 8191), 0);
        send(mk_alloc(131071, 8), 0);
        send(mk_alloc(65536, 8), 0);
        send(mk_free(0), 0);
        send(mk_free(8), 0);
        send(mk_free(20), 0);
        send(mk_free(65535), 0);
        send(mk_free(16), 0);
        send(mk_free(16), 0);
        send(mk_free(48), 0);
        write_arena(17'd32);
        send(mk_alloc(65520, 8), 0);
        send(mk_alloc(1, 8), 0);
        send(mk_free(16), 0);
        write_arena(17'd33);
        send(mk_alloc(17, 8), 0);
        send(mk_alloc(8, 8), 0);
        send(mk_free(16), 0);
        write_arena(17'h1FFFF);
        send(mk_alloc(65520, 0), 0);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: a = 65536;
                1: a = 512;
                2: a = $urandom_range(33, 4096);
                default: a = 0;
            endcase
            write_arena(17'(a));
            for (int i = 0; i < 150; i++)
            begin
                send(rand_req(), ph != 3 || i > 75);
                if (i == 60)
                    drain();
            end
        end
        drain();
        $display("ran %0d requests over several arena sizes, incl. tiny and full arenas",
                 sent);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("first_fit_heap_allocator test passed");
        else
            $display("first_fit_heap_allocator test failed");
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/ffh_pkg.sv
rtl/core/ffh_hdr_ram.sv
rtl/core/ffh_size_round.sv
rtl/core/first_fit_heap_allocator.sv
tb/tb_top.sv
